// ===== design/distinct_address_counter_assert.svh =====
// Assertion macros shared by the distinct address counter RTL.
`ifndef DISTINCT_ADDRESS_COUNTER_ASSERT_SVH
`define DISTINCT_ADDRESS_COUNTER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Check a property on every clock edge once reset is released.
`define DAC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define DAC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define DAC_ASSERT(label, prop, msg)
`define DAC_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== design/dac_pkg.sv =====
// Shared constants and types of the distinct address counter.
package dac_pkg;

  localparam int unsigned AddrW = 64;
  localparam int unsigned EntryW = AddrW + 1;
  localparam int unsigned CountW = 13;
  localparam logic [CountW-1:0] CountMax = 13'd8191;

  localparam int unsigned BucketsDef = 1024;
  localparam int unsigned WaysDef = 4;

  // Outcome of one bucket lookup
  typedef struct packed {
    logic found;
    logic was_new;
    logic overflow;
  } dac_flags_t;

endpackage

// ===== design/dac_if.sv =====
// Request and result channel interfaces of the distinct address counter.
interface dac_req_if import dac_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [AddrW-1:0]  address;

  modport source (output valid, output address, input ready);
  modport sink   (input valid, input address, output ready);
endinterface

interface dac_rsp_if import dac_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              was_new;
  logic [CountW-1:0] distinct_total;
  logic              overflow;

  modport source (output valid, output was_new, output distinct_total, output overflow,
                  input ready);
  modport sink   (input valid, input was_new, input distinct_total, input overflow,
                  output ready);
endinterface

// ===== design/dac_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module dac_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/dac_row_update.sv =====
// Bucket row lookup: match the address against valid ways, fill the first free way.
module dac_row_update import dac_pkg::*; #(
  parameter int unsigned Ways = WaysDef,
  localparam int unsigned RowW = Ways * EntryW
) (
  input  logic [AddrW-1:0] addr_i,
  input  logic [RowW-1:0]  row_i,
  output logic [RowW-1:0]  row_o,
  output dac_flags_t       flags_o
);

  logic [Ways-1:0] hit;
  logic [Ways-1:0] free;
  logic [Ways-1:0] pick;

  // Compare every valid way against the address
  always_comb begin
    for (int unsigned w = 0; w < Ways; w++) begin
      free[w] = !row_i[w*EntryW + AddrW];
      hit[w]  = !free[w] && (row_i[w*EntryW +: AddrW] == addr_i);
    end
  end

  // Select the lowest-numbered free way
  always_comb begin
    logic taken;
    taken = 1'b0;
    for (int unsigned w = 0; w < Ways; w++) begin
      pick[w] = free[w] && !taken;
      taken   = taken || free[w];
    end
  end

  // Build flags and the new row
  always_comb begin
    flags_o.found    = |hit;
    flags_o.was_new  = !flags_o.found && (|free);
    flags_o.overflow = !flags_o.found && !(|free);
    row_o = row_i;
    for (int unsigned w = 0; w < Ways; w++) begin
      if (flags_o.was_new && pick[w]) begin
        row_o[w*EntryW +: EntryW] = {1'b1, addr_i};
      end
    end
  end

endmodule

// ===== design/distinct_address_counter.sv =====
// Distinct address counter: bounded hash set of addresses with a running distinct count.
//
//   channel  | port   | dir | payload
//   ---------+--------+-----+-------------------------------------------
//   request  | req_i  | in  | address[63:0]
//   result   | rsp_o  | out | was_new, distinct_total[12:0], overflow
//
// One request per cycle sustained outside stalls and the clearing pass; a result passes the
// lookup and output registers before it is offered. The row memory is read when a request is
// taken and written back as it leaves the lookup stage; a request taken during that write-back
// uses the forwarded row. After reset a clearing pass zeroes the row memory, one row per cycle,
// with req_i.ready low. An untaken result stalls the lookup stage and the request side.
`include "distinct_address_counter_assert.svh"

module distinct_address_counter import dac_pkg::*; #(
  parameter int unsigned Buckets = BucketsDef,
  parameter int unsigned Ways = WaysDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dac_req_if.sink   req_i,
  dac_rsp_if.source rsp_o
);

  localparam int unsigned IdxW = (Buckets > 1) ? $clog2(Buckets) : 1;
  localparam int unsigned RowW = Ways * EntryW;

  logic              clearing_q;
  logic [IdxW-1:0]   clr_idx_q;

  logic              s1_valid_q;
  logic [AddrW-1:0]  s1_addr_q;
  logic [IdxW-1:0]   s1_idx_q;

  logic              fwd_valid_q;
  logic [IdxW-1:0]   fwd_idx_q;
  logic [RowW-1:0]   fwd_row_q;

  logic [CountW-1:0] cnt_q, cnt_d;

  logic              out_valid_q;
  logic              out_new_q;
  logic              out_ovf_q;
  logic [CountW-1:0] out_total_q;

  logic              req_take;
  logic              s1_adv;
  logic [IdxW-1:0]   req_idx;
  logic [RowW-1:0]   ram_rdata;
  logic [RowW-1:0]   cur_row;
  logic [RowW-1:0]   new_row;
  dac_flags_t        flags;
  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  logic [RowW-1:0]   ram_wdata;
  logic              count_up;

  // Handshake and bucket selection
  assign s1_adv    = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !clearing_q && (!s1_valid_q || s1_adv);
  assign req_take  = req_i.valid && req_i.ready;
  assign req_idx   = req_i.address[IdxW-1:0] & IdxW'(Buckets - 1);

  // Pick forwarded row when the previous write hit this bucket
  assign cur_row = (fwd_valid_q && (fwd_idx_q == s1_idx_q)) ? fwd_row_q : ram_rdata;

  dac_row_update #(.Ways(Ways)) u_row_update (
    .addr_i  (s1_addr_q),
    .row_i   (cur_row),
    .row_o   (new_row),
    .flags_o (flags)
  );

  // Write back a changed row, or zero rows during the clearing pass
  assign ram_we    = clearing_q || (s1_adv && flags.was_new);
  assign ram_waddr = clearing_q ? clr_idx_q : s1_idx_q;
  assign ram_wdata = clearing_q ? '0 : new_row;

  dac_ram #(.Width(RowW), .Depth(Buckets)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (req_take),
    .raddr_i (req_idx),
    .rdata_o (ram_rdata)
  );

  // Saturating distinct count
  assign count_up = s1_adv && flags.was_new && (cnt_q != CountMax);
  assign cnt_d    = count_up ? cnt_q + CountW'(1) : cnt_q;

  // Clearing pass sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_idx_q  <= '0;
    end else if (clearing_q) begin
      clr_idx_q <= clr_idx_q + IdxW'(1);
      if (clr_idx_q == IdxW'(Buckets - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // Lookup stage control and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (req_take) begin
        s1_valid_q  <= 1'b1;
        fwd_valid_q <= s1_adv && flags.was_new;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // Lookup stage payload and forwarded row
  always_ff @(posedge clk_i) begin
    if (req_take) begin
      s1_addr_q <= req_i.address;
      s1_idx_q  <= req_idx;
      fwd_idx_q <= s1_idx_q;
      fwd_row_q <= new_row;
    end
  end

  // Output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_new_q   <= flags.was_new;
      out_ovf_q   <= flags.overflow;
      out_total_q <= cnt_d;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.was_new        = out_new_q;
  assign rsp_o.overflow       = out_ovf_q;
  assign rsp_o.distinct_total = out_total_q;

  // Checks
  `DAC_ASSERT(a_no_req_while_clearing, clearing_q |-> !req_i.ready, "request taken during clear")
  `DAC_ASSERT(a_count_step, $stable(cnt_q) || (cnt_q == $past(cnt_q) + CountW'(1)), "count jumped")
  `DAC_ASSERT(a_count_on_new, count_up |=> (cnt_q == $past(cnt_q) + CountW'(1)), "new not counted")
  `DAC_ASSERT(a_no_write_on_stall, (s1_valid_q && !s1_adv) |-> !ram_we, "row written on stall")
  `DAC_ASSERT_ALWAYS(a_new_xor_ovf, out_valid_q |-> !(out_new_q && out_ovf_q), "new and overflow")

endmodule
